>>> rtl/core/fractal_hash_value_noise_core_macros.svh
// ----------------------------------------------------------------------------
// fractal hash value noise core assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FRACTAL_HASH_VALUE_NOISE_CORE_MACROS_SVH
`define FRACTAL_HASH_VALUE_NOISE_CORE_MACROS_SVH

// plain property under clock and active-low reset
`define FHVN_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next
`define FHVN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    `FHVN_ASSERT(lbl, clk, rstn, (ante) |=> (cons), msg)

`endif

>>> rtl/core/fhvn_pkg.sv
// ----------------------------------------------------------------------------
// fhvn_pkg
// shared types, tables and constants of the fractal hash value noise core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhvn_pkg;

    localparam int OCT_W      = 4;
    localparam int POS_W      = 32;
    localparam int SAMPLE_W   = 16;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 16;
    localparam int FREQ_DEPTH = 16;

    // frequency per octave, unsigned q16, f(o+1) = floor(f(o) * 21 / 10)
    typedef logic [32:0] freq_tab_t [FREQ_DEPTH];

    function automatic freq_tab_t freq_table();
        freq_tab_t   tab;
        logic [39:0] f;
        f = 40'd65536;
        for (int i = 0; i < FREQ_DEPTH; i++) begin
            tab[i] = f[32:0];
            f      = (f * 40'd21) / 40'd10;
        end
        return tab;
    endfunction

    localparam freq_tab_t FREQ_TAB = freq_table();

    // per-octave offset step of each axis, q16
    localparam logic [17:0] OFF_STEP [3] = '{18'd242483, 18'd137626, 18'd98304};

    // hash constants
    localparam logic [31:0] HASH_MUL [3] = '{32'd1619, 32'd31337, 32'd6971};
    localparam logic [31:0] GOLDEN       = 32'h9e37_79b9;

    // saturation bounds of the 32-bit hash operand, as magnitudes
    localparam logic [33:0] SAT_NEG = 34'h0_8000_0000;
    localparam logic [33:0] SAT_POS = 34'h0_7FFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             issue;
        logic [OCT_W-1:0] oct;
        logic             div_start;
        logic             div_step;
        logic             out_load;
    } fhvn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [OCT_W-1:0] oct_n;
        logic             pipe_busy;
    } fhvn_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/fhvn_ctrl.sv
// ----------------------------------------------------------------------------
// fhvn_ctrl
// sequencer: octave issue, pipeline drain, divide steps, result handoff
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhvn_ctrl
    import fhvn_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire fhvn_stat_t stat,
    output fhvn_cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [3:0] DIV_LAST = 4'd15;

    logic [2:0]       state_reg, state_next;
    logic [OCT_W-1:0] oct_cnt_reg, oct_cnt_next;
    logic [3:0]       div_cnt_reg, div_cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb begin
        state_next   = state_reg;
        oct_cnt_next = oct_cnt_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load     = 1'b1;
                    oct_cnt_next = '0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN: begin
                if (oct_cnt_reg == stat.oct_n) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.issue    = 1'b1;
                    cmd.oct      = oct_cnt_reg;
                    oct_cnt_next = oct_cnt_reg + OCT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!stat.pipe_busy) begin
                    if (stat.oct_n == '0) begin
                        state_next = ST_FIN;
                    end else begin
                        cmd.div_start = 1'b1;
                        div_cnt_next  = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oct_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oct_cnt_reg   <= oct_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/fhvn_dp.sv
// ----------------------------------------------------------------------------
// fhvn_dp
// octave pipeline (scale, saturate, hash), weighted accumulator, divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhvn_dp
    import fhvn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [POS_W-1:0]    pos_x,
    input  wire logic [POS_W-1:0]    pos_y,
    input  wire logic [POS_W-1:0]    pos_z,
    input  wire logic [OCT_W-1:0]    octave_count,
    input  wire fhvn_cmd_t           cmd,
    output fhvn_stat_t               stat,
    output logic [SAMPLE_W-1:0]      noise_value
);

    localparam int K     = FRAC_BITS + 16;   // fraction bits of pos * freq
    localparam int MW    = K + 23;           // clamped magnitude width
    localparam int SW    = K + 24;           // signed offset sum width
    localparam int RW    = K + 10;           // fraction times 1000
    localparam int ACC_W = SAMPLE_W + MAX_OCTAVES;
    localparam int REM_W = MAX_OCTAVES;
    localparam int NSTG  = 10;

    localparam logic [MW-1:0]  CLAMP_MAG = {1'b1, {(MW-1){1'b0}}};
    localparam logic [REM_W:0] DEN_ONE   = (REM_W+1)'(1);

    // operands held for the whole item
    logic [POS_W-1:0] mag_reg [3];
    logic [2:0]       neg_reg;
    logic [OCT_W-1:0] n_reg;
    logic [POS_W-1:0] pos_in [3];
    logic [OCT_W-1:0] n_next;

    // pipeline control
    logic [NSTG-1:0]  v_reg;
    logic [OCT_W-1:0] oct_reg [NSTG];

    // lane registers and their next values
    logic [48:0]      plo_reg [3], plo_next [3];
    logic [47:0]      phi_reg [3], phi_next [3];
    logic [64:0]      pm_next [3];
    logic [MW-1:0]    pmc_reg [3], pmc_next [3];
    logic [21:0]      off_next [3];
    logic [SW-1:0]    offsh_next [3];
    logic [SW-1:0]    s_reg [3], s_next [3];
    logic [SW-1:0]    sabs_next [3];
    logic [MW-1:0]    m_reg [3], m_next [3];
    logic [2:0]       sneg4_reg, sneg5_reg;
    logic [32:0]      qt_reg [3], qt_next [3];
    logic [RW-1:0]    rt_reg [3], rt_next [3];
    logic [33:0]      t_next [3], tc_next [3];
    logic [31:0]      ix_reg [3], ix_next [3];
    logic [31:0]      hp_reg [3], hp_next [3];
    logic [31:0]      hs_next;
    logic [31:0]      h_reg, h_next;
    logic [31:0]      g_reg, g_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;

    // accumulator and divider
    logic [OCT_W-1:0] sh_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [REM_W:0]   den_wide;
    logic [REM_W-1:0] den;
    logic [REM_W:0]   rem_sh, rem_diff;
    logic             q_bit;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [SAMPLE_W-1:0] dq_reg, dq_next;
    logic [SAMPLE_W-1:0] out_reg;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    assign n_next = (5'(octave_count) > 5'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES)
                                                          : octave_count;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg <= n_next;
            for (int a = 0; a < 3; a++) begin
                neg_reg[a] <= pos_in[a][POS_W-1];
                mag_reg[a] <= pos_in[a][POS_W-1] ? (POS_W'(0) - pos_in[a]) : pos_in[a];
            end
        end
    end

    // lane arithmetic, stages one to seven
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            // stage 1: split 32x33 product into two partials
            plo_next[a] = 49'(mag_reg[a]) * 49'(FREQ_TAB[cmd.oct][16:0]);
            phi_next[a] = 48'(mag_reg[a]) * 48'(FREQ_TAB[cmd.oct][32:17]);
            // stage 2: recombine and clamp the magnitude
            pm_next[a]  = 65'(plo_reg[a]) + (65'(phi_reg[a]) << 17);
            pmc_next[a] = (pm_next[a] > 65'(CLAMP_MAG)) ? CLAMP_MAG : pm_next[a][MW-1:0];
            // stage 3: apply sign, add axis offset
            off_next[a]   = 22'(oct_reg[1]) * 22'(OFF_STEP[a]);
            offsh_next[a] = SW'(off_next[a]) << FRAC_BITS;
            s_next[a]     = neg_reg[a] ? (offsh_next[a] - SW'(pmc_reg[a]))
                                       : (offsh_next[a] + SW'(pmc_reg[a]));
            // stage 4: magnitude of the sum, clamped
            sabs_next[a] = s_reg[a][SW-1] ? (SW'(0) - s_reg[a]) : s_reg[a];
            m_next[a]    = (sabs_next[a] > SW'(CLAMP_MAG)) ? CLAMP_MAG
                                                           : sabs_next[a][MW-1:0];
            // stage 5: times 1000, integer and fraction parts apart
            qt_next[a] = 33'(m_reg[a][MW-1:K]) * 33'(1000);
            rt_next[a] = RW'(m_reg[a][K-1:0]) * RW'(1000);
            // stage 6: truncate, saturate to 32 bits
            t_next[a] = 34'(qt_reg[a]) + 34'(rt_reg[a] >> K);
            if (sneg5_reg[a]) begin
                tc_next[a] = (t_next[a] > SAT_NEG) ? SAT_NEG : t_next[a];
                ix_next[a] = 32'd0 - tc_next[a][31:0];
            end else begin
                tc_next[a] = (t_next[a] > SAT_POS) ? SAT_POS : t_next[a];
                ix_next[a] = tc_next[a][31:0];
            end
            // stage 7: hash products
            hp_next[a] = ix_reg[a] * HASH_MUL[a];
        end
    end

    // hash tail, stages eight to ten
    assign hs_next  = hp_reg[0] + hp_reg[1] + hp_reg[2];
    assign h_next   = hs_next ^ (hs_next >> 13);
    assign g_next   = h_reg * GOLDEN;
    assign smp_next = g_reg[15:0] ^ g_reg[26:11];

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            plo_reg[a] <= plo_next[a];
            phi_reg[a] <= phi_next[a];
            pmc_reg[a] <= pmc_next[a];
            s_reg[a]   <= s_next[a];
            m_reg[a]   <= m_next[a];
            sneg4_reg[a] <= s_reg[a][SW-1];
            qt_reg[a]  <= qt_next[a];
            rt_reg[a]  <= rt_next[a];
            ix_reg[a]  <= ix_next[a];
            hp_reg[a]  <= hp_next[a];
        end
        sneg5_reg <= sneg4_reg;
        h_reg     <= h_next;
        g_reg     <= g_next;
        smp_reg   <= smp_next;
        oct_reg[0] <= cmd.oct;
        for (int i = 1; i < NSTG; i++) begin
            oct_reg[i] <= oct_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[NSTG-2:0], cmd.issue};
        end
    end

    // weight 2^(n-1-o) on the last stage
    assign sh_next = n_reg - OCT_W'(1) - oct_reg[NSTG-1];

    always_comb begin
        priority if (cmd.load) begin
            acc_next = '0;
        end else if (v_reg[NSTG-1]) begin
            acc_next = acc_reg + (ACC_W'(smp_reg) << sh_next);
        end else begin
            acc_next = acc_reg;
        end
    end

    // restoring divide by 2^n - 1, quotient known to fit in 16 bits
    assign den_wide = (DEN_ONE << n_reg) - DEN_ONE;
    assign den      = den_wide[REM_W-1:0];
    assign rem_sh   = {rem_reg, dq_reg[SAMPLE_W-1]};
    assign rem_diff = rem_sh - {1'b0, den};
    assign q_bit    = (rem_sh >= {1'b0, den});

    always_comb begin
        rem_next = rem_reg;
        dq_next  = dq_reg;
        priority if (cmd.load) begin
            dq_next = '0;
        end else if (cmd.div_start) begin
            rem_next = acc_reg[ACC_W-1:SAMPLE_W];
            dq_next  = acc_reg[SAMPLE_W-1:0];
        end else if (cmd.div_step) begin
            rem_next = q_bit ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            dq_next  = {dq_reg[SAMPLE_W-2:0], q_bit};
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        if (cmd.out_load) begin
            out_reg <= dq_reg;
        end
    end

    assign stat.oct_n     = n_reg;
    assign stat.pipe_busy = |v_reg;
    assign noise_value    = out_reg;

endmodule

`default_nettype wire

>>> rtl/core/fractal_hash_value_noise_core.sv
// ----------------------------------------------------------------------------
// fractal_hash_value_noise_core
// fbm value noise of a q-format 3-d point over up to MAX_OCTAVES octaves
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata fields (low bit up)                       tuser  tlast
//  s_        in    pos_x[31:0] pos_y[63:32] pos_z[95:64] cnt[99:96]  -      -
//  m_        out   noise_value[15:0]                                -      -
//
//  one point at a time; the clamped octaves are issued, the pipeline drains,
//  16 divide steps run, then the handoff moves the word to the output
//  register; zero octaves skip the divide and go straight to the handoff
//  a finished word waits in the output register; the next point is taken
//  while it waits, and only the final handoff stalls on m_tready
//  aresetn is synchronous, active low; clears sequencer and valid bits
//
`timescale 1ns / 1ps
`default_nettype none

module fractal_hash_value_noise_core
    import fhvn_pkg::*;
#(
    parameter int MAX_OCTAVES = 8,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // pos_x, pos_y, pos_z, octave_count, zero fill to 104 bits
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // noise_value
    output logic [M_TDATA_W-1:0]      m_tdata
);

    fhvn_cmd_t  cmd;
    fhvn_stat_t stat;

    // word layout of the input channel
    logic [POS_W-1:0] pos_x, pos_y, pos_z;
    logic [OCT_W-1:0] octave_count;

    assign pos_x        = s_tdata[31:0];
    assign pos_y        = s_tdata[63:32];
    assign pos_z        = s_tdata[95:64];
    assign octave_count = s_tdata[99:96];

    // sequencer: issue octaves, wait for drain, run divider, hand off
    fhvn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // octave pipeline, accumulator, divider and output register
    fhvn_dp #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .octave_count (octave_count),
        .cmd          (cmd),
        .stat         (stat),
        .noise_value  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/fhvn_checker.sv
// ----------------------------------------------------------------------------
// fhvn_checker
// port-level checks of the noise core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fractal_hash_value_noise_core_macros.svh"

module fhvn_checker
    import fhvn_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result word stays offered
    `FHVN_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result word withdrawn")

    // a stalled result word keeps its value
    `FHVN_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata), "result word changed")

    // one point in flight: input closes after each accepted word
    `FHVN_ASSERT_NEXT(a_single_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second point taken while busy")

    // a new result always returns the core to idle
    `FHVN_ASSERT(a_done_idle, aclk, aresetn, $rose(m_tvalid) |-> s_tready, "result without return to idle")

endmodule

bind fractal_hash_value_noise_core fhvn_checker u_fhvn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
